// ===== hdl/char_lcd_nibble_writer_top_macros.svh =====
// Assertion helpers for the top-level RTL; clock and reset come from the enclosing module.
`ifndef CHAR_LCD_NIBBLE_WRITER_TOP_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITER_TOP_MACROS_SVH

// cons must hold in the same cycle as ante
`define LCDNW_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lcdnw same-cycle check failed");

// cons must hold in the cycle after ante
`define LCDNW_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lcdnw next-cycle check failed");

`endif

// ===== hdl/lcdnw_pkg.sv =====
package lcdnw_pkg;

   localparam int unsigned NUM_W   = 32;
   localparam int unsigned DIGITS  = 10;
   localparam int unsigned BCD_W   = 4 * DIGITS;
   localparam int unsigned Q_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_INSTR  = 2'd0,
      OP_DATA   = 2'd1,
      OP_GOTO   = 2'd2,
      OP_NUMBER = 2'd3
   } opcode_type;

   localparam logic [7:0] CURSOR_CMD = 8'h80;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // classified request handed from front to back
   typedef struct packed {
      logic             is_num;
      logic             rs;
      logic             neg;
      logic [7:0]       byte_val;
      logic [BCD_W-1:0] bcd;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [7:0] row_base(input logic [1:0] row);
      logic [7:0] base;
      unique case (row)
         2'd0:    base = 8'h00;
         2'd1:    base = 8'h40;
         2'd2:    base = 8'h14;
         default: base = 8'h54;
      endcase
      return base;
   endfunction

endpackage

// ===== hdl/char_lcd_nibble_writer_top.sv =====
// Character LCD writer, 4-bit bus. Each request becomes a run of response beats, one per
// enable strobe: RS level in rsp_tuser, D7..D4 in rsp_tdata[3:0], high nibble of each byte
// first, rsp_tlast on the final strobe of the run. Opcodes: instruction byte (RS low), data
// byte (RS high), cursor goto (0x80 + row base + column, column clamped to LCD_COLUMNS-1),
// and signed decimal number (optional '-', then digits, "0" for zero; 2 to 22 strobes).
// The front end registers a request as it takes it and offers a byte or goto request to the
// queue in the next cycle; a number first passes bit by bit through the bit-serial
// binary-to-BCD converter. The front end takes no new request until the last one has gone
// to the queue, so it stalls while the queue has no room for the finished request.
// A two-entry queue lets the back end drive strobes for earlier requests meanwhile; the back
// end first loads a request into its command register and then gives one strobe per cycle
// while rsp_tready stays high. Strobe timing and LCD init are left to the consumer.
`include "char_lcd_nibble_writer_top_macros.svh"

module char_lcd_nibble_writer_top #(
   parameter int unsigned LCD_COLUMNS = 20   // visible cells per line, 8 to 20
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // byte_value[7:0], row[9:8], column[14:10], number[46:15]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   // strobe channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // nibble[3:0], zero pad[7:4]
   output logic [0:0]  rsp_tuser,   // reg_select[0]
   output logic        rsp_tlast    // last_strobe
);
   import lcdnw_pkg::*;

   // front end -> queue
   logic         push_valid;
   logic         push_ready;
   cmd_type      push_cmd;
   // queue -> back end
   logic         pop_valid;
   logic         pop_ready;
   cmd_type      pop_cmd;
   q_status_type q_status;

   logic [3:0]   rsp_nibble;
   logic         rsp_rs;

   lcdnw_front #(
      .LCD_COLUMNS (LCD_COLUMNS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .opcode     (opcode_type'(req_tuser)),
      .byte_value (req_tdata[7:0]),
      .row        (req_tdata[9:8]),
      .column     (req_tdata[14:10]),
      .number     (signed'(req_tdata[46:15])),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   lcdnw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .status     (q_status)
   );

   lcdnw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_rs     (rsp_rs),
      .out_nibble (rsp_nibble),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, rsp_nibble};
   assign rsp_tuser = rsp_rs;

   // a stalled hand-off to the queue keeps the entry unchanged
   `LCDNW_ASSERT_NEXT(a_push_hold, push_valid && !push_ready, push_valid && $stable(push_cmd))
   // a non-number request reaches the queue interface on the next cycle
   `LCDNW_ASSERT_NEXT(a_byte_fast, req_tvalid && req_tready && (req_tuser != OP_NUMBER),
                      push_valid)
   // front end takes nothing new while it holds an entry
   `LCDNW_ASSERT_SAME(a_front_busy, push_valid, !req_tready)
   // queue flags never contradict
   `LCDNW_ASSERT_SAME(a_q_flags, q_status.full, !q_status.empty && !push_ready)

endmodule

// ===== hdl/lcdnw_front.sv =====
module lcdnw_front #(
   parameter int unsigned LCD_COLUMNS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  lcdnw_pkg::opcode_type opcode,
   input  logic [7:0]            byte_value,
   input  logic [1:0]            row,
   input  logic [4:0]            column,
   input  logic signed [31:0]    number,
   output logic                  push_valid,
   input  logic                  push_ready,
   output lcdnw_pkg::cmd_type    push_cmd
);
   import lcdnw_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CONV = 3'b010,
      F_PUSH = 3'b100
   } fstate_type;

   localparam logic [4:0] COL_MAX  = 5'(LCD_COLUMNS - 1);
   localparam logic [4:0] LAST_BIT = 5'(NUM_W - 1);

   fstate_type       state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [NUM_W-1:0] mag_ff, mag_in;
   logic [4:0]       cnt_ff, cnt_in;

   logic [4:0]       col_sat;
   logic [7:0]       goto_byte;
   logic [NUM_W-1:0] num_u;
   logic [NUM_W-1:0] num_abs;
   logic [BCD_W-1:0] bcd_adj;

   assign col_sat   = (column > COL_MAX) ? COL_MAX : column;
   assign goto_byte = CURSOR_CMD + row_base(row) + {3'b000, col_sat};
   assign num_u     = unsigned'(number);
   assign num_abs   = num_u[NUM_W-1] ? (~num_u + {{(NUM_W-1){1'b0}}, 1'b1}) : num_u;

   // add-3 correction of each BCD digit before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (cmd_ff.bcd[4*i +: 4] >= 4'd5) ?
                             (cmd_ff.bcd[4*i +: 4] + 4'd3) : cmd_ff.bcd[4*i +: 4];
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      mag_in   = mag_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (in_valid) begin
               cmd_in.is_num = (opcode == OP_NUMBER);
               cmd_in.rs     = (opcode == OP_DATA) || (opcode == OP_NUMBER);
               cmd_in.neg    = num_u[NUM_W-1];
               cmd_in.bcd    = '0;
               cmd_in.byte_val = (opcode == OP_GOTO) ? goto_byte : byte_value;
               mag_in   = num_abs;
               cnt_in   = '0;
               state_in = (opcode == OP_NUMBER) ? F_CONV : F_PUSH;
            end
         end
         F_CONV: begin
            cmd_in.bcd = {bcd_adj[BCD_W-2:0], mag_ff[NUM_W-1]};
            mag_in     = {mag_ff[NUM_W-2:0], 1'b0};
            cnt_in     = cnt_ff + 5'd1;
            if (cnt_ff == LAST_BIT) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      mag_ff <= mag_in;
      cnt_ff <= cnt_in;
   end

   assign in_ready   = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_cmd   = cmd_ff;

endmodule

// ===== hdl/lcdnw_queue.sv =====
module lcdnw_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  lcdnw_pkg::cmd_type      push_cmd,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output lcdnw_pkg::cmd_type      pop_cmd,
   output lcdnw_pkg::q_status_type status
);
   import lcdnw_pkg::*;

   localparam logic [1:0] FULL_CNT = 2'(Q_DEPTH);

   cmd_type    entry_ff [Q_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != 2'd0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_cmd    = entry_ff[rd_ptr_ff];

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == 2'd0);

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/lcdnw_back.sv =====
module lcdnw_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  lcdnw_pkg::cmd_type pop_cmd,
   output logic               out_valid,
   input  logic               out_ready,
   output logic               out_rs,
   output logic [3:0]         out_nibble,
   output logic               out_last
);
   import lcdnw_pkg::*;

   cmd_type    cmd_ff, cmd_in;
   logic       busy_ff, busy_in;
   logic       lo_ff, lo_in;
   logic       sign_ff, sign_in;
   logic [3:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic       rs_ff, rs_in;
   logic [3:0] nib_ff, nib_in;
   logic       last_ff, last_in;

   logic [3:0] lead;
   logic [3:0] digit;
   logic [7:0] cur_char;
   logic       out_free;
   logic       final_char;

   // most significant nonzero digit; zero prints as a single '0'
   always_comb begin
      lead = 4'd0;
      for (int i = 0; i < DIGITS; i++) begin
         if (pop_cmd.bcd[4*i +: 4] != 4'd0) begin
            lead = 4'(i);
         end
      end
   end

   assign digit      = cmd_ff.bcd[{idx_ff, 2'b00} +: 4];
   assign cur_char   = sign_ff ? CHAR_MINUS :
                       (cmd_ff.is_num ? (CHAR_ZERO | {4'b0000, digit}) : cmd_ff.byte_val);
   assign out_free   = !valid_ff || out_ready;
   assign final_char = !sign_ff && (!cmd_ff.is_num || (idx_ff == 4'd0));
   assign pop_ready  = !busy_ff;

   always_comb begin
      cmd_in   = cmd_ff;
      busy_in  = busy_ff;
      lo_in    = lo_ff;
      sign_in  = sign_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff && !out_ready;
      rs_in    = rs_ff;
      nib_in   = nib_ff;
      last_in  = last_ff;
      if (!busy_ff) begin
         if (pop_valid) begin
            cmd_in  = pop_cmd;
            busy_in = 1'b1;
            lo_in   = 1'b0;
            sign_in = pop_cmd.is_num && pop_cmd.neg;
            idx_in  = lead;
         end
      end else if (out_free) begin
         valid_in = 1'b1;
         rs_in    = cmd_ff.rs;
         nib_in   = lo_ff ? cur_char[3:0] : cur_char[7:4];
         last_in  = lo_ff && final_char;
         lo_in    = !lo_ff;
         if (lo_ff) begin
            if (sign_ff) begin
               sign_in = 1'b0;
            end else if (!final_char) begin
               idx_in = idx_ff - 4'd1;
            end else begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      lo_ff   <= lo_in;
      sign_ff <= sign_in;
      idx_ff  <= idx_in;
      rs_ff   <= rs_in;
      nib_ff  <= nib_in;
      last_ff <= last_in;
   end

   assign out_valid  = valid_ff;
   assign out_rs     = rs_ff;
   assign out_nibble = nib_ff;
   assign out_last   = last_ff;

endmodule

// ===== tb/char_lcd_nibble_writer_top_tb.sv =====
module char_lcd_nibble_writer_top_tb;
   import lcdnw_pkg::*;

   localparam int unsigned COLUMNS      = 20;
   // A number passes through the converter before its strobes start.
   localparam int unsigned DRAIN_CYCLES = 60;
   localparam int unsigned PHASE_ITEMS  = 150;

   // one enable strobe as seen on the response side
   typedef struct packed {
      logic       rs;
      logic [3:0] nibble;
      logic       last;
   } lcd_strobe_type;

   // Expands each accepted request into its strobe run and checks the strobes in order.
   class strobe_scoreboard;
      lcd_strobe_type expected_strobes[$];
      int unsigned    mismatches;
      int unsigned    columns;
      logic [7:0]     line_base[4];

      function new(int unsigned cols);
         columns    = cols;
         mismatches = 0;
         line_base  = '{8'h00, 8'h40, 8'h14, 8'h54};
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         mismatches++;
      endtask

      // bytes of the run, then two strobes per byte, high nibble first
      function void note_request(opcode_type op, logic [7:0] byte_value, logic [1:0] row,
                                 logic [4:0] column, logic [31:0] number);
         logic [7:0]     chars[$];
         logic [7:0]     digits[$];
         logic [31:0]    mag;
         logic           rs;
         lcd_strobe_type s;
         rs = (op == OP_DATA) || (op == OP_NUMBER);
         case (op) inside
            OP_INSTR, OP_DATA: begin
               chars.push_back(byte_value);
            end
            OP_GOTO: begin
               // column past the line end sticks at the last cell
               mag = (column > columns - 1) ? columns - 1 : column;
               chars.push_back(CURSOR_CMD + line_base[row] + mag[7:0]);
            end
            default: begin
               mag = number;
               if (number[31]) begin
                  chars.push_back(CHAR_MINUS);
                  mag = -number;   // unsigned negate, so 0x80000000 stays 2147483648
               end
               if (mag == 0) chars.push_back(CHAR_ZERO);
               while (mag != 0) begin
                  digits.push_front(CHAR_ZERO + 8'(mag % 10));
                  mag = mag / 10;
               end
               foreach (digits[i]) chars.push_back(digits[i]);
            end
         endcase
         foreach (chars[i]) begin
            s.rs     = rs;
            s.nibble = chars[i][7:4];
            s.last   = 1'b0;
            expected_strobes.push_back(s);
            s.nibble = chars[i][3:0];
            s.last   = (i == chars.size() - 1);
            expected_strobes.push_back(s);
         end
      endfunction

      task check_strobe(logic rs, logic [3:0] nibble, logic last);
         lcd_strobe_type want;
         if (expected_strobes.size() == 0) begin
            report($sformatf("strobe rs=%0d nibble=%h last=%0d with none expected",
                             rs, nibble, last));
            return;
         end
         want = expected_strobes.pop_front();
         if (rs !== want.rs)
            report($sformatf("reg_select %0d, expected %0d", rs, want.rs));
         if (nibble !== want.nibble)
            report($sformatf("nibble %h, expected %h", nibble, want.nibble));
         if (last !== want.last)
            report($sformatf("last_strobe %0d, expected %0d", last, want.last));
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // byte_value[7:0], row[9:8], column[14:10], number[46:15]
   logic [1:0]  req_tuser  = '0;   // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // nibble[3:0], zero pad[7:4]
   logic [0:0]  rsp_tuser;         // reg_select[0]
   logic        rsp_tlast;

   // idle odds in percent for the request and strobe sides
   int unsigned send_idle = 0;
   int unsigned recv_idle = 0;

   strobe_scoreboard board = new(COLUMNS);

   char_lcd_nibble_writer_top #(
      .LCD_COLUMNS (COLUMNS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Monitor: sees the values that the block saw at this edge, since all of our
   // drives land later in the step as nonblocking updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_request(opcode_type'(req_tuser), req_tdata[7:0], req_tdata[9:8],
                               req_tdata[14:10], req_tdata[46:15]);
         if (rsp_tvalid && rsp_tready)
            board.check_strobe(rsp_tuser[0], rsp_tdata[3:0], rsp_tlast);
      end
   end

   // strobe side back-pressure
   always @(posedge clock) begin
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle);
   end

   // Offers one request, possibly after a random gap, and returns at the edge that
   // takes it. valid stays high into the next call unless that call idles first.
   task automatic send_request(opcode_type op, logic [7:0] byte_value, logic [1:0] row,
                               logic [4:0] column, logic [31:0] number);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, number, column, row, byte_value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Numbers shaped to hit every digit count, digit rollovers and the sign extremes.
   function automatic logic [31:0] rand_number();
      logic [31:0] p;
      int unsigned k;
      p = 1;
      case ($urandom_range(3))
         0: return $urandom();
         1: return 32'($urandom_range(198)) - 32'd99;
         2: begin
            k = $urandom_range(9);
            repeat (k) p = p * 10;
            p = p + $urandom_range(2) - 1;   // one below, at, or above a power of ten
            return $urandom_range(1) ? -p : p;
         end
         default: begin
            case ($urandom_range(3))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'hFFFF_FFFF;
               default: return 32'h0000_0000;
            endcase
         end
      endcase
   endfunction

   // Unused fields carry random bits too; the block must ignore them.
   task automatic send_random_request();
      opcode_type  op;
      logic [31:0] number;
      op     = opcode_type'($urandom_range(3));
      number = (op == OP_NUMBER) ? rand_number() : $urandom();
      send_request(op, 8'($urandom), 2'($urandom), 5'($urandom), number);
   endtask

   // Holds requests back until every strobe is in, then lets the converter settle.
   // The first edge lets the monitor note the request taken at the previous one.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.expected_strobes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: byte extremes, all rows, clamped columns, number edge cases
      send_request(OP_INSTR,  8'h00, 2'd0, 5'd0,  32'h0000_0000);
      send_request(OP_INSTR,  8'hFF, 2'd3, 5'd31, 32'hFFFF_FFFF);
      send_request(OP_DATA,   8'h00, 2'd3, 5'd31, 32'hFFFF_FFFF);
      send_request(OP_DATA,   8'hFF, 2'd0, 5'd0,  32'h0000_0000);
      send_request(OP_DATA,   8'h41, 2'd1, 5'd10, 32'h1234_5678);
      send_request(OP_GOTO,   8'h00, 2'd0, 5'd0,  32'h0000_0000);
      send_request(OP_GOTO,   8'hFF, 2'd1, 5'd19, 32'hFFFF_FFFF);
      send_request(OP_GOTO,   8'h00, 2'd2, 5'd20, 32'h0000_0000);   // one past the line end
      send_request(OP_GOTO,   8'hFF, 2'd3, 5'd31, 32'hFFFF_FFFF);   // widest column
      send_request(OP_GOTO,   8'h5A, 2'd3, 5'd19, 32'hA5A5_A5A5);
      send_request(OP_NUMBER, 8'hFF, 2'd3, 5'd31, 32'h0000_0000);   // zero prints "0"
      send_request(OP_NUMBER, 8'h00, 2'd0, 5'd0,  32'h0000_0001);
      send_request(OP_NUMBER, 8'h00, 2'd0, 5'd0,  32'hFFFF_FFFF);   // -1
      send_request(OP_NUMBER, 8'h00, 2'd0, 5'd0,  32'h0000_0009);
      send_request(OP_NUMBER, 8'h00, 2'd0, 5'd0,  32'h0000_000A);
      send_request(OP_NUMBER, 8'h00, 2'd0, 5'd0,  32'h7FFF_FFFF);   // largest positive
      send_request(OP_NUMBER, 8'h00, 2'd0, 5'd0,  32'h8000_0000);   // most negative, 22 strobes
      send_request(OP_NUMBER, 8'h00, 2'd0, 5'd0,  32'h3B9A_CA00);   // 1000000000
      send_request(OP_NUMBER, 8'h00, 2'd0, 5'd0,  32'hB669_FD2E);   // -1234567890
      send_request(OP_NUMBER, 8'h00, 2'd0, 5'd0,  32'hEE6B_2800);   // -294967296
      // Sender holds off here until the whole directed run is out.
      wait_for_drain();

      // random traffic in three idle profiles, draining between them
      send_idle = 29;
      recv_idle = 87;
      repeat (PHASE_ITEMS) send_random_request();
      wait_for_drain();

      send_idle = 87;
      recv_idle = 29;
      repeat (PHASE_ITEMS) send_random_request();
      wait_for_drain();

      send_idle = 0;
      recv_idle = 0;
      repeat (PHASE_ITEMS) send_random_request();
      wait_for_drain();

      if (board.expected_strobes.size() != 0)
         board.report($sformatf("%0d expected strobes never came",
                                board.expected_strobes.size()));

      if (board.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #6_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
